/* hw/rtl/ecpa_pkg.sv */
// Package for the elliptic curve point adder.
// Holds the status type shared by the sequencer and the arithmetic unit,
// and the reset value of the modulus register. Depends on nothing.
package ecpa_pkg;

  // Reset value of the field prime, before masking to the coordinate width.
  localparam int unsigned ModulusReset = 65521;

  // Status of the shared divide/multiply-accumulate unit.
  typedef struct packed {
    logic busy;  // an operation is being stepped
    logic done;  // one-cycle pulse: remainder and product are valid
  } mac_stat_t;

endpackage : ecpa_pkg

/* hw/rtl/ecpa_if.sv */
// Valid/ready channel interfaces for the elliptic curve point adder.
// ecpa_in_if carries the two input points, ecpa_out_if the sum point.
// Depends on nothing.
interface ecpa_in_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] p_x;
  logic [COORD_WIDTH-1:0] p_y;
  logic [COORD_WIDTH-1:0] q_x;
  logic [COORD_WIDTH-1:0] q_y;

  modport source (output valid, output p_x, output p_y, output q_x, output q_y,
                  input ready);
  modport sink (input valid, input p_x, input p_y, input q_x, input q_y,
                output ready);
endinterface : ecpa_in_if

interface ecpa_out_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] sum_x;
  logic [COORD_WIDTH-1:0] sum_y;
  logic                   no_inverse;

  modport source (output valid, output sum_x, output sum_y, output no_inverse,
                  input ready);
  modport sink (input valid, input sum_x, input sum_y, input no_inverse,
                output ready);
endinterface : ecpa_out_if

/* hw/rtl/ecpa_mac_unit.sv */
// Shared bit-serial divide and modular multiply-accumulate unit.
// Depends on ecpa_pkg for the status struct.
// Gives rem = D mod V and acc = (D / V) * A mod p, one quotient bit a cycle.
module ecpa_mac_unit import ecpa_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [COORD_WIDTH-1:0] dividend_i,
  input  logic [COORD_WIDTH-1:0] divisor_i,
  input  logic [COORD_WIDTH-1:0] mcand_i,
  input  logic [COORD_WIDTH-1:0] modulus_i,
  output logic [COORD_WIDTH-1:0] rem_o,
  output logic [COORD_WIDTH-1:0] acc_o,
  output mac_stat_t              stat_o
);

  localparam int unsigned CntW = $clog2(COORD_WIDTH);

  logic [COORD_WIDTH-1:0] dvd_q, dvs_q, mcd_q;
  logic [COORD_WIDTH-1:0] rem_q, rem_d, acc_q, acc_d, acc_dbl;
  logic [CntW-1:0]        cnt_q;
  logic                   busy_q, done_q;
  logic [COORD_WIDTH:0]   rem_sh, rem_nx;
  logic                   qbit;

  // Modular addition of two residues below p, with one compare.
  function automatic logic [COORD_WIDTH-1:0] fadd(
    input logic [COORD_WIDTH-1:0] a,
    input logic [COORD_WIDTH-1:0] b,
    input logic [COORD_WIDTH-1:0] p
  );
    logic [COORD_WIDTH-1:0] gap;
    gap = p - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

  // One restoring division step; the quotient bit drives the Horner step.
  always_comb begin
    rem_sh  = {rem_q, dvd_q[cnt_q]};
    qbit    = (rem_sh >= {1'b0, dvs_q});
    rem_nx  = qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    rem_d   = rem_nx[COORD_WIDTH-1:0];
    acc_dbl = fadd(acc_q, acc_q, modulus_i);
    acc_d   = qbit ? fadd(acc_dbl, mcd_q, modulus_i) : acc_dbl;
  end

  // Control: the bit counter runs from the top bit of the dividend down.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(COORD_WIDTH - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Operands and partial results.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      mcd_q <= mcand_i;
      rem_q <= '0;
      acc_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      acc_q <= acc_d;
    end
  end

  assign rem_o       = rem_q;
  assign acc_o       = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule : ecpa_mac_unit

/* hw/rtl/ec_point_add_mod_p.sv */
// Affine point addition P + Q on an elliptic curve over GF(p), p set by the
// modulus register (reset 65521). All arithmetic goes through one bit-serial
// divide/multiply-accumulate unit, which flags completion in the cycle after
// its last step; every operation has its own load and write-back steps: four
// reductions of the inputs, one division per extended Euclid step for the x
// difference, then three modular multiplications. The input is not ready while
// an item is in flight. When the x coordinates agree mod p, the difference has
// no inverse, or the modulus is below two, no_inverse is set and both sum
// coordinates read zero.
//
// Depends on ecpa_pkg, ecpa_if and ecpa_mac_unit.
module ec_point_add_mod_p import ecpa_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [COORD_WIDTH-1:0] cfg_wdata_i,
  ecpa_in_if.sink                in_i,
  ecpa_out_if.source             out_o
);

  localparam logic [COORD_WIDTH-1:0] ModRst = COORD_WIDTH'(ModulusReset);
  localparam logic [COORD_WIDTH-1:0] One    = COORD_WIDTH'(1);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_RED_LD  = 4'd1;
  localparam logic [3:0] ST_RED_WB  = 4'd2;
  localparam logic [3:0] ST_DIFF    = 4'd3;
  localparam logic [3:0] ST_EUC_CHK = 4'd4;
  localparam logic [3:0] ST_EUC_UPD = 4'd5;
  localparam logic [3:0] ST_M_WB    = 4'd6;
  localparam logic [3:0] ST_X3      = 4'd7;
  localparam logic [3:0] ST_D_LD    = 4'd8;
  localparam logic [3:0] ST_Y3      = 4'd9;
  localparam logic [3:0] ST_MACC    = 4'd10;
  localparam logic [3:0] ST_OUT     = 4'd11;

  logic [3:0]             state_q, ret_q;
  logic [1:0]             idx_q;
  logic [COORD_WIDTH-1:0] modulus_q;
  logic [COORD_WIDTH-1:0] x1_q, y1_q, x2_q, y2_q, dy_q, m_q;
  logic [COORD_WIDTH-1:0] r0_q, r1_q, t0_q, t1_q;
  logic [COORD_WIDTH-1:0] sx_q, sy_q;
  logic                   ni_q, out_valid_q;
  logic [COORD_WIDTH-1:0] dx, red_sel;

  logic                   mac_start;
  logic [COORD_WIDTH-1:0] mac_dvd, mac_dvs, mac_mcd, mac_rem, mac_acc;
  mac_stat_t              mac_stat;

  // Modular subtraction of two residues below p.
  function automatic logic [COORD_WIDTH-1:0] fsub(
    input logic [COORD_WIDTH-1:0] a,
    input logic [COORD_WIDTH-1:0] b,
    input logic [COORD_WIDTH-1:0] p
  );
    return (a >= b) ? (a - b) : (a + (p - b));
  endfunction

  assign dx = fsub(x2_q, x1_q, modulus_q);

  // Coordinate to be reduced in this pass.
  always_comb begin
    unique case (idx_q)
      2'd0:    red_sel = x1_q;
      2'd1:    red_sel = y1_q;
      2'd2:    red_sel = x2_q;
      default: red_sel = y2_q;
    endcase
  end

  // Operands for the shared unit. A plain product a*b is b divided by one
  // with a as multiplicand; a reduction is the product with one.
  always_comb begin
    mac_start = 1'b0;
    mac_dvd   = t0_q;
    mac_dvs   = One;
    mac_mcd   = One;
    unique case (state_q)
      ST_RED_LD: begin
        mac_start = 1'b1;
        mac_dvd   = red_sel;
      end
      ST_EUC_CHK: begin
        mac_start = (r1_q != '0) || (r0_q == One);
        if (r1_q != '0) begin
          mac_dvd = r0_q;
          mac_dvs = r1_q;
          mac_mcd = t1_q;
        end else begin
          mac_dvd = t0_q;
          mac_mcd = dy_q;
        end
      end
      ST_M_WB: begin
        mac_start = 1'b1;
        mac_dvd   = mac_acc;
        mac_mcd   = mac_acc;
      end
      ST_D_LD: begin
        mac_start = 1'b1;
        mac_dvd   = fsub(x1_q, sx_q, modulus_q);
        mac_mcd   = m_q;
      end
      default: begin
        mac_start = 1'b0;
      end
    endcase
  end

  ecpa_mac_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mac_start),
    .dividend_i (mac_dvd),
    .divisor_i  (mac_dvs),
    .mcand_i    (mac_mcd),
    .modulus_i  (modulus_q),
    .rem_o      (mac_rem),
    .acc_o      (mac_acc),
    .stat_o     (mac_stat)
  );

  // Control state and the modulus register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      modulus_q   <= ModRst;
    end else begin
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            idx_q <= '0;
            if (modulus_q < COORD_WIDTH'(2)) begin
              out_valid_q <= 1'b1;
              state_q     <= ST_OUT;
            end else begin
              state_q <= ST_RED_LD;
            end
          end
        end
        ST_RED_LD: begin
          ret_q   <= ST_RED_WB;
          state_q <= ST_MACC;
        end
        ST_RED_WB: begin
          idx_q   <= idx_q + 2'd1;
          state_q <= (idx_q == 2'd3) ? ST_DIFF : ST_RED_LD;
        end
        ST_DIFF: begin
          if (dx == '0) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
          end else begin
            state_q <= ST_EUC_CHK;
          end
        end
        ST_EUC_CHK: begin
          if (r1_q != '0) begin
            ret_q   <= ST_EUC_UPD;
            state_q <= ST_MACC;
          end else if (r0_q == One) begin
            ret_q   <= ST_M_WB;
            state_q <= ST_MACC;
          end else begin
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
          end
        end
        ST_EUC_UPD: state_q <= ST_EUC_CHK;
        ST_M_WB: begin
          ret_q   <= ST_X3;
          state_q <= ST_MACC;
        end
        ST_X3:   state_q <= ST_D_LD;
        ST_D_LD: begin
          ret_q   <= ST_Y3;
          state_q <= ST_MACC;
        end
        ST_Y3: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_OUT;
        end
        ST_MACC: begin
          if (mac_stat.done) begin
            state_q <= ret_q;
          end
        end
        ST_OUT: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers of the point addition.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        x1_q <= in_i.p_x;
        y1_q <= in_i.p_y;
        x2_q <= in_i.q_x;
        y2_q <= in_i.q_y;
        sx_q <= '0;
        sy_q <= '0;
        ni_q <= 1'b1;
      end
      ST_RED_WB: begin
        unique case (idx_q)
          2'd0:    x1_q <= mac_acc;
          2'd1:    y1_q <= mac_acc;
          2'd2:    x2_q <= mac_acc;
          default: y2_q <= mac_acc;
        endcase
      end
      ST_DIFF: begin
        dy_q <= fsub(y2_q, y1_q, modulus_q);
        r0_q <= modulus_q;
        r1_q <= dx;
        t0_q <= '0;
        t1_q <= One;
      end
      ST_EUC_UPD: begin
        r0_q <= r1_q;
        r1_q <= mac_rem;
        t0_q <= t1_q;
        t1_q <= fsub(t0_q, mac_acc, modulus_q);
      end
      ST_M_WB: m_q <= mac_acc;
      ST_X3:   sx_q <= fsub(fsub(mac_acc, x1_q, modulus_q), x2_q, modulus_q);
      ST_Y3: begin
        sy_q <= fsub(mac_acc, y1_q, modulus_q);
        ni_q <= 1'b0;
      end
      default: begin
        ni_q <= ni_q;
      end
    endcase
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.sum_x      = sx_q;
  assign out_o.sum_y      = sy_q;
  assign out_o.no_inverse = ni_q;

  // The shared unit is never restarted while it is still stepping.
  a_mac_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_start |-> !mac_stat.busy)
    else $error("arithmetic unit started while busy");

  // A result waiting for transfer blocks new input.
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while a result is pending");

  // A flagged result carries zero coordinates.
  a_noinv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.no_inverse) |-> (out_o.sum_x == '0 && out_o.sum_y == '0))
    else $error("non-zero coordinates with no_inverse set");

  // A good result lies in the field.
  a_sum_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.no_inverse) |->
      (out_o.sum_x < modulus_q && out_o.sum_y < modulus_q))
    else $error("sum coordinate not reduced below the modulus");

  // An accepted item starts work: the input closes in the next cycle.
  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input still ready after a transfer");

endmodule : ec_point_add_mod_p

/* tb/ec_point_add_mod_p_tb.sv */
// Self-checking testbench for the elliptic curve point adder ec_point_add_mod_p.
// Depends on ecpa_pkg, the ecpa_in_if/ecpa_out_if channels and the block itself.
`timescale 1ns / 1ps

module ec_point_add_mod_p_tb import ecpa_pkg::*; ();

  localparam int unsigned CW = 16;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 600;
  localparam int unsigned PHASE_ITEMS = 180;
  localparam bit PINNED = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct packed {
    logic [CW-1:0] p_x;
    logic [CW-1:0] p_y;
    logic [CW-1:0] q_x;
    logic [CW-1:0] q_y;
  } point_pair_t;

  typedef struct packed {
    logic [CW-1:0] sum_x;
    logic [CW-1:0] sum_y;
    logic          no_inverse;
  } sum_pt_t;

  // One row of the directed table: modulus, both points and, where it is
  // obvious, the sum that must come back.
  typedef struct packed {
    logic [CW-1:0] prime;
    logic [CW-1:0] p_x;
    logic [CW-1:0] p_y;
    logic [CW-1:0] q_x;
    logic [CW-1:0] q_y;
    logic          pinned;
    logic [CW-1:0] ex_x;
    logic [CW-1:0] ex_y;
    logic          ex_ni;
  } dir_row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we;
  logic [CW-1:0] cfg_wdata;

  ecpa_in_if  #(.COORD_WIDTH(CW)) in_ch ();
  ecpa_out_if #(.COORD_WIDTH(CW)) out_ch ();

  ec_point_add_mod_p #(
    .COORD_WIDTH(CW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Sums still owed by the block, oldest first, and the modulus it holds.
  sum_pt_t       sum_q[$];
  logic [CW-1:0] field_prime;
  int unsigned   fail_count;
  int unsigned   idle_cycles;
  bit            quiet;
  bit            pin_on;
  sum_pt_t       pin_val;

  dir_row_t dir_rows[22];

  // Affine addition of two distinct points over GF(p).
  function automatic sum_pt_t predict_sum(point_pair_t pts, logic [CW-1:0] prime);
    longint p, x1, y1, x2, y2, dx, dy, inv, m, x3, y3;
    longint r0, r1, t0, t1, q, tmp;
    sum_pt_t res;
    res = '0;
    res.no_inverse = 1'b1;
    p = longint'(prime);
    if (p < 2) return res;
    x1 = longint'(pts.p_x) % p;
    y1 = longint'(pts.p_y) % p;
    x2 = longint'(pts.q_x) % p;
    y2 = longint'(pts.q_y) % p;
    dx = (x2 + p - x1) % p;
    dy = (y2 + p - y1) % p;
    if (dx == 0) return res;
    // Extended Euclid on (p, dx); the inverse exists only for gcd one.
    r0 = p;
    r1 = dx;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q   = r0 / r1;
      tmp = r0 - q * r1;
      r0  = r1;
      r1  = tmp;
      tmp = t0 - q * t1;
      t0  = t1;
      t1  = tmp;
    end
    if (r0 != 1) return res;
    inv = ((t0 % p) + p) % p;
    m   = (dy * inv) % p;
    x3  = ((m * m) % p + 2 * p - x1 - x2) % p;
    y3  = ((m * ((x1 + p - x3) % p)) % p + p - y1) % p;
    res.sum_x = CW'(x3);
    res.sum_y = CW'(y3);
    res.no_inverse = 1'b0;
    return res;
  endfunction

  // Mostly well-formed points below the modulus, with equal x coordinates,
  // raw 16-bit noise and extreme values mixed in.
  function automatic point_pair_t random_pair(int unsigned p);
    point_pair_t pts;
    int unsigned kind, shifted;
    logic [CW-1:0] picks[4];
    kind = $urandom_range(0, 9);
    pts.p_x = CW'($urandom_range(0, p - 1));
    pts.p_y = CW'($urandom_range(0, p - 1));
    pts.q_x = CW'($urandom_range(0, p - 1));
    pts.q_y = CW'($urandom_range(0, p - 1));
    if (kind == 7) begin
      shifted = pts.p_x + p;
      pts.q_x = ($urandom_range(0, 1) && shifted < 65536) ? CW'(shifted) : pts.p_x;
    end else if (kind == 8) begin
      pts = point_pair_t'({$urandom(), $urandom()});
    end else if (kind == 9) begin
      picks = '{CW'(0), CW'(p - 1), {CW{1'b1}}, CW'(p)};
      pts.p_x = picks[$urandom_range(0, 3)];
      pts.p_y = picks[$urandom_range(0, 3)];
      pts.q_x = picks[$urandom_range(0, 3)];
      pts.q_y = picks[$urandom_range(0, 3)];
    end
    return pts;
  endfunction

  // Presents one pair of points and holds it until the transfer, then maybe
  // leaves a gap on the input.
  task automatic send_pair(point_pair_t pts, bit pinned, sum_pt_t exp);
    in_ch.valid <= 1'b1;
    in_ch.p_x   <= pts.p_x;
    in_ch.p_y   <= pts.p_y;
    in_ch.q_x   <= pts.q_x;
    in_ch.q_y   <= pts.q_y;
    pin_on      <= pinned;
    pin_val     <= exp;
    do @(posedge clk_i); while (!in_ch.ready);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // The modulus is only changed once every owed sum has come back.
  task automatic write_modulus(logic [CW-1:0] value);
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sum_q.size() != 0);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Every input starts at a known value.
  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.p_x    = '0;
    in_ch.p_y    = '0;
    in_ch.q_x    = '0;
    in_ch.q_y    = '0;
    out_ch.ready = 1'b0;
    pin_on       = 1'b0;
    pin_val      = '0;
    quiet        = 1'b0;
    fail_count   = 0;
    idle_cycles  = 0;
    field_prime  = CW'(ModulusReset);
  end

  // Result side: ready drops in short bursts, with long calm stretches.
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 60) == 0) begin
        repeat ($urandom_range(100, 400)) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed table first, then random phases over several moduli.
  initial begin
    dir_row_t    row;
    point_pair_t pts;
    sum_pt_t     exp;
    int unsigned phase_mod[8];

    dir_rows = '{
      '{16'd65521, 16'd0, 16'd0, 16'd1, 16'd1, PINNED, 16'd0, 16'd0, 1'b0},
      '{16'd65521, 16'd1, 16'd0, 16'd0, 16'd0, PINNED, 16'd65520, 16'd0, 1'b0},
      '{16'd65521, 16'd5, 16'd7, 16'd5, 16'd9, PINNED, 16'd0, 16'd0, 1'b1},
      '{16'd65521, 16'd5, 16'd7, 16'd5, 16'd65514, PINNED, 16'd0, 16'd0, 1'b1},
      '{16'd65521, 16'd65535, 16'd65535, 16'd0, 16'd0, PREDICTED, 16'd0, 16'd0, 1'b0},
      '{16'd65521, 16'd65521, 16'd3, 16'd0, 16'd9, PINNED, 16'd0, 16'd0, 1'b1},
      '{16'd65521, 16'd65520, 16'd65520, 16'd0, 16'd0, PREDICTED, 16'd0, 16'd0, 1'b0},
      '{16'd65521, 16'd0, 16'd65535, 16'd65535, 16'd0, PREDICTED, 16'd0, 16'd0, 1'b0},
      '{16'd65521, 16'd12345, 16'd54321, 16'd777, 16'd4242, PREDICTED, 16'd0, 16'd0, 1'b0},
      '{16'd65521, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, PREDICTED, 16'd0, 16'd0, 1'b0},
      '{16'd65535, 16'd0, 16'd0, 16'd3, 16'd1, PINNED, 16'd0, 16'd0, 1'b1},
      '{16'd65535, 16'd0, 16'd0, 16'd2, 16'd1, PREDICTED, 16'd0, 16'd0, 1'b0},
      '{16'd65535, 16'd0, 16'd0, 16'd257, 16'd0, PINNED, 16'd0, 16'd0, 1'b1},
      '{16'd3, 16'd0, 16'd0, 16'd1, 16'd1, PINNED, 16'd0, 16'd0, 1'b0},
      '{16'd3, 16'd2, 16'd1, 16'd0, 16'd2, PREDICTED, 16'd0, 16'd0, 1'b0},
      '{16'd3, 16'd65535, 16'd65535, 16'd65534, 16'd0, PREDICTED, 16'd0, 16'd0, 1'b0},
      '{16'd2, 16'd0, 16'd1, 16'd1, 16'd0, PREDICTED, 16'd0, 16'd0, 1'b0},
      '{16'd2, 16'd1, 16'd1, 16'd3, 16'd0, PINNED, 16'd0, 16'd0, 1'b1},
      '{16'd1, 16'd0, 16'd0, 16'd1, 16'd1, PINNED, 16'd0, 16'd0, 1'b1},
      '{16'd0, 16'd0, 16'd0, 16'd1, 16'd1, PINNED, 16'd0, 16'd0, 1'b1},
      '{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0, PINNED, 16'd0, 16'd0, 1'b1},
      '{16'd65521, 16'd100, 16'd200, 16'd300, 16'd400, PREDICTED, 16'd0, 16'd0, 1'b0}
    };
    phase_mod = '{65521, 251, 65535, 3, 4093, 0, 221, 65521};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; the modulus is rewritten whenever a row asks for another.
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (i != 0 && row.prime != dir_rows[i - 1].prime) write_modulus(row.prime);
      pts = '{row.p_x, row.p_y, row.q_x, row.q_y};
      exp = '{row.ex_x, row.ex_y, row.ex_ni};
      send_pair(pts, row.pinned, exp);
    end

    // Random phases; the last one runs with no idling on either side.
    foreach (phase_mod[ph]) begin
      if (phase_mod[ph] == 0) phase_mod[ph] = $urandom_range(3, 65535);
      write_modulus(CW'(phase_mod[ph]));
      quiet = (ph == 7);
      repeat (PHASE_ITEMS) send_pair(random_pair(phase_mod[ph]), PREDICTED, '0);
    end

    // Drain, then make sure nothing further comes out.
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sum_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    fail_count += sum_q.size();
    if (fail_count == 0) begin
      $display("ec_point_add_mod_p_tb OK");
    end else begin
      $display("ec_point_add_mod_p_tb NOT OK");
    end
    $finish;
  end

  // Records each accepted pair and checks each sum against the oldest owed one.
  always @(posedge clk_i) begin
    point_pair_t seen;
    sum_pt_t     want;
    sum_pt_t     got;
    if (rst_ni) begin
      if (cfg_we) field_prime = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        seen = '{in_ch.p_x, in_ch.p_y, in_ch.q_x, in_ch.q_y};
        sum_q.insert(sum_q.size(), pin_on ? pin_val : predict_sum(seen, field_prime));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.sum_x, out_ch.sum_y, out_ch.no_inverse};
        if (sum_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: sum (%0d, %0d, no_inverse %0b) with none owed",
                     $realtime, got.sum_x, got.sum_y, got.no_inverse);
        end else begin
          want = sum_q.pop_front();
          if (got.sum_x !== want.sum_x || got.sum_y !== want.sum_y ||
              got.no_inverse !== want.no_inverse) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: sum mismatch, expected (%0d, %0d, %0b) got (%0d, %0d, %0b)",
                       $realtime, want.sum_x, want.sum_y, want.no_inverse,
                       got.sum_x, got.sum_y, got.no_inverse);
          end
        end
      end
    end
  end

  // Watchdog: too long without any transfer or register write ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("ec_point_add_mod_p_tb NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule : ec_point_add_mod_p_tb

/* files.f */
hw/rtl/ecpa_pkg.sv
hw/rtl/ecpa_if.sv
hw/rtl/ecpa_mac_unit.sv
hw/rtl/ec_point_add_mod_p.sv
tb/ec_point_add_mod_p_tb.sv
